// File: rtl/core/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTF8SD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 stream decoder check failed");

// next-cycle implication, checked outside reset
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 stream decoder check failed");

`endif

// File: rtl/core/utf8sd_pkg.sv
// shared types and constants for the utf8 stream decoder
`default_nettype none

package utf8sd_pkg;

   localparam int unsigned CpWidth = 31;

   localparam logic [CpWidth-1:0] REPLACEMENT = 31'h0000_003F;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LONE    = 2'd1,
      ST_BAD     = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   // lead that still waits for the overlong check on its first follow word
   typedef enum logic [2:0] {
      OVL_NONE = 3'd0,
      OVL_E0   = 3'd1,
      OVL_F0   = 3'd2,
      OVL_F8   = 3'd3,
      OVL_FC   = 3'd4
   } ovl_kind_type;

   typedef struct packed {
      logic [2:0]         bytes_remaining;
      logic [CpWidth-1:0] partial_value;
      logic               sequence_bad;
      ovl_kind_type       ovl_kind;
   } dec_state_type;

   typedef struct packed {
      logic               valid;
      logic [CpWidth-1:0] code_point;
      status_type         status;
      logic               final_result;
   } dec_result_type;

   localparam dec_state_type STATE_IDLE = '{
      bytes_remaining: 3'd0,
      partial_value:   '0,
      sequence_bad:    1'b0,
      ovl_kind:        OVL_NONE
   };

endpackage

`default_nettype wire

// File: rtl/core/utf8sd_step.sv
// next-state and result logic for one text word
`default_nettype none

module utf8sd_step
   import utf8sd_pkg::*;
(
   input  dec_state_type  cur_state,
   input  logic [7:0]     data_byte,
   input  logic           end_of_text,
   output dec_state_type  nxt_state,
   output dec_result_type result
);

   logic       cont;
   logic [7:0] limit;
   logic       too_small;
   logic       bad_n;
   logic [2:0] rem_n;
   logic [CpWidth-1:0] pv_n;

   assign cont = (data_byte[7:6] == 2'b10);

   always_comb begin
      case (cur_state.ovl_kind)
         OVL_E0:  limit = 8'hA0;
         OVL_F0:  limit = 8'h90;
         OVL_F8:  limit = 8'h88;
         OVL_FC:  limit = 8'h84;
         default: limit = 8'h00;
      endcase
   end

   assign too_small = cont && (data_byte < limit);
   assign bad_n     = cur_state.sequence_bad | ~cont;
   assign rem_n     = cur_state.bytes_remaining - 3'd1;
   assign pv_n      = (cont && !cur_state.sequence_bad)
                    ? {cur_state.partial_value[CpWidth-7:0], data_byte[5:0]}
                    : cur_state.partial_value;

   always_comb begin
      nxt_state           = cur_state;
      result.valid        = 1'b0;
      result.code_point   = '0;
      result.status       = ST_OK;
      result.final_result = end_of_text;

      if (cur_state.bytes_remaining != 3'd0) begin
         if (too_small) begin
            // overlong form: drop the lead, this word is a lone continuation
            nxt_state     = STATE_IDLE;
            result.valid  = 1'b1;
            result.status = ST_LONE;
         end else if (rem_n == 3'd0 || end_of_text) begin
            nxt_state    = STATE_IDLE;
            result.valid = 1'b1;
            if (bad_n || rem_n != 3'd0) begin
               result.code_point = REPLACEMENT;
               result.status     = ST_BAD;
            end else begin
               result.code_point = pv_n;
            end
         end else begin
            nxt_state.bytes_remaining = rem_n;
            nxt_state.partial_value   = pv_n;
            nxt_state.sequence_bad    = bad_n;
            nxt_state.ovl_kind        = OVL_NONE;
         end
      end else if (!data_byte[7]) begin
         result.valid      = 1'b1;
         result.code_point = {{(CpWidth-8){1'b0}}, data_byte};
      end else if (cont) begin
         result.valid  = 1'b1;
         result.status = ST_LONE;
      end else if (data_byte[7:1] == 7'h60) begin
         // c0 and c1 leads are dropped silently
         nxt_state = STATE_IDLE;
      end else if (data_byte[7:1] == 7'h7F) begin
         result.valid  = 1'b1;
         result.status = ST_INVALID;
      end else if (end_of_text) begin
         result.valid      = 1'b1;
         result.code_point = REPLACEMENT;
         result.status     = ST_BAD;
      end else begin
         nxt_state.sequence_bad = 1'b0;
         if (data_byte[7:1] == 7'h7E) begin
            nxt_state.bytes_remaining = 3'd5;
            nxt_state.partial_value   = {{(CpWidth-1){1'b0}}, data_byte[0]};
         end else if (data_byte[7:2] == 6'h3E) begin
            nxt_state.bytes_remaining = 3'd4;
            nxt_state.partial_value   = {{(CpWidth-2){1'b0}}, data_byte[1:0]};
         end else if (data_byte[7:3] == 5'h1E) begin
            nxt_state.bytes_remaining = 3'd3;
            nxt_state.partial_value   = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
         end else if (data_byte[7:4] == 4'hE) begin
            nxt_state.bytes_remaining = 3'd2;
            nxt_state.partial_value   = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
         end else begin
            nxt_state.bytes_remaining = 3'd1;
            nxt_state.partial_value   = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
         end
         case (data_byte)
            8'hE0:   nxt_state.ovl_kind = OVL_E0;
            8'hF0:   nxt_state.ovl_kind = OVL_F0;
            8'hF8:   nxt_state.ovl_kind = OVL_F8;
            8'hFC:   nxt_state.ovl_kind = OVL_FC;
            default: nxt_state.ovl_kind = OVL_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/utf8_stream_decoder.sv
// top level of the utf8 stream decoder
// Decodes a stream of text words (one byte each, the last marked by
// end_of_text) into code points, accepting the original 1 to 6 byte forms.
// One word is taken per clock without gaps while rsp_stall is not held: a
// word is held in the input register, is decoded by a single shallow step
// against the sequence state and lands in the result register, which drives
// rsp_valid. A word gives at most one result: leads of longer forms, follow
// words in the middle of a sequence and c0/c1 leads give none. While a result
// waits under rsp_stall the input register can still take one word if it is
// empty, then req_stall rises with it, so throughput drops only when the
// consumer holds rsp_stall. No reset pass is needed.
`default_nettype none

module utf8_stream_decoder
   import utf8sd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic [1:0]         rsp_status,
   output logic               rsp_final_result
);

`include "utf8_stream_decoder_assert.svh"

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // sequence state
   dec_state_type state_ff, state_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CpWidth-1:0] rsp_cp_ff;
   status_type         rsp_status_ff;
   logic               rsp_final_ff;

   logic           accept;
   logic           advance;
   logic           take;
   dec_result_type step_res;

   // result register can load when empty or being drained this cycle
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign take      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   utf8sd_step u_step (
      .cur_state   (state_ff),
      .data_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .nxt_state   (state_in),
      .result      (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   // a word that yields nothing leaves the result register empty
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = take & step_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_eot_ff  <= req_end_of_text;
      end
      if (advance) begin
         rsp_cp_ff     <= step_res.code_point;
         rsp_status_ff <= step_res.status;
         rsp_final_ff  <= step_res.final_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = rsp_cp_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_final_result = rsp_final_ff;

   // an overlong check is only pending right after a three-byte or longer lead
   `UTF8SD_ASSERT_NOW(a_ovl_needs_seq, clock, reset,
      state_ff.ovl_kind != OVL_NONE, state_ff.bytes_remaining >= 3'd2)

   // idle state carries no leftovers
   `UTF8SD_ASSERT_NOW(a_idle_clean, clock, reset,
      state_ff.bytes_remaining == 3'd0,
      state_ff.partial_value == '0 && !state_ff.sequence_bad)

   // bad or truncated sequences always report the replacement character
   `UTF8SD_ASSERT_NOW(a_bad_is_repl, clock, reset,
      rsp_valid_ff && rsp_status_ff == ST_BAD, rsp_cp_ff == REPLACEMENT)

   // a word held back by a full result register is not lost
   `UTF8SD_ASSERT_NEXT(a_held_word, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
